// ===== design/ilt_pkg.sv =====
// Shared definitions for the indexed list table: op and status codes,
// fixed port widths, default sizes and the control struct sent to each cell.
// No dependencies.
package ilt_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push;
    logic write;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== design/ilt_cell.sv =====
// One storage cell of the list table chain; cell Index holds list position Index.
// Takes its neighbors' words on push and remove, compares for find.
// Depends on ilt_pkg.
module ilt_cell #(
  parameter int Index      = 0,
  parameter int DataWidth  = ilt_pkg::DATA_WIDTH_DEF,
  parameter int CountWidth = 5
) (
  input  logic                 clk_i,
  input  ilt_pkg::cell_ctl_t   ctl_i,
  input  logic [ilt_pkg::POS_W-1:0] pos_i,
  input  logic [DataWidth-1:0] value_i,
  input  logic [CountWidth-1:0] count_i,
  input  logic [DataWidth-1:0] prev_i,
  input  logic [DataWidth-1:0] next_i,
  output logic [DataWidth-1:0] data_o,
  output logic                 hit_o,
  output logic                 match_o
);

  logic [DataWidth-1:0] data_q, data_d;
  logic sel, at_or_after, valid;

  assign sel         = (32'(Index) == 32'(pos_i));
  assign at_or_after = (32'(Index) >= 32'(pos_i));
  assign valid       = (32'(Index) < 32'(count_i));

  always_comb begin
    data_d = data_q;
    if (ctl_i.push) begin
      data_d = prev_i;
    end else if (ctl_i.write && sel) begin
      data_d = value_i;
    end else if (ctl_i.remove && at_or_after) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign hit_o   = sel && valid;
  assign match_o = valid && (data_q == value_i);

endmodule

// ===== design/indexed_list_table.sv =====
// Indexed list table: a list of at most DEPTH signed words, newest at the head.
// Requests enter on start_i with op_i, position_i and value_i. busy_o is always
// low, so an item is accepted at every edge where start_i is high: push at head,
// read, write or remove at a position counted from the head, or find a value.
// Each item gives one result in the cycle after it is accepted, marked by done_o for one
// cycle: read_value_o, found_position_o, found_o, status_o and count_o (count
// after the item). Throughput is one item per cycle, set by the row of cells
// that shift, write and compare all entries at once.
// Find reports the match nearest the tail; no match gives found_o low.
// A push to a full list answers status full; a read, write or remove at a
// position at or beyond the count answers status range; neither changes the list.
// The receiver cannot stall; results are not held.
// Reset empties the list (count zero); stored words are not cleared.
// Depends on ilt_pkg and ilt_cell.
module indexed_list_table #(
  parameter int DEPTH      = ilt_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ilt_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [ilt_pkg::OP_W-1:0]         op_i,
  input  logic [ilt_pkg::POS_W-1:0]        position_i,
  input  logic signed [ilt_pkg::VAL_W-1:0] value_i,
  output logic                             done_o,
  output logic signed [ilt_pkg::VAL_W-1:0] read_value_o,
  output logic [ilt_pkg::POS_W-1:0]        found_position_o,
  output logic                             found_o,
  output logic [ilt_pkg::STAT_W-1:0]       status_o,
  output logic [ilt_pkg::CNT_W-1:0]        count_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0] count_q, count_d;
  logic          done_q;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic [IW-1:0] fpos_q, fpos_d;
  logic          found_q, found_d;
  logic [ilt_pkg::STAT_W-1:0] status_q, status_d;

  logic [DATA_WIDTH-1:0] val_w;
  logic full, in_range;
  logic is_push, is_read, is_write, is_remove, is_find;
  ilt_pkg::cell_ctl_t ctl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_hit, cell_match;

  assign busy_o = 1'b0;
  assign val_w  = DATA_WIDTH'(64'($unsigned(value_i)));

  assign full     = (count_q == CW'(DEPTH));
  assign in_range = (32'(position_i) < 32'(count_q));

  assign is_push   = (op_i == ilt_pkg::OP_PUSH);
  assign is_read   = (op_i == ilt_pkg::OP_READ);
  assign is_write  = (op_i == ilt_pkg::OP_WRITE);
  assign is_remove = (op_i == ilt_pkg::OP_REMOVE);
  assign is_find   = (op_i == ilt_pkg::OP_FIND);

  assign ctl.push   = start_i && is_push && !full;
  assign ctl.write  = start_i && is_write && in_range;
  assign ctl.remove = start_i && is_remove && in_range;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (k == 0) begin : g_first
      assign prev_w = val_w;
    end else begin : g_mid
      assign prev_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_w = cell_data[k];
    end else begin : g_inner
      assign next_w = cell_data[k+1];
    end
    ilt_cell #(
      .Index     (k),
      .DataWidth (DATA_WIDTH),
      .CountWidth(CW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pos_i  (position_i),
      .value_i(val_w),
      .count_i(count_q),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[k]),
      .hit_o  (cell_hit[k]),
      .match_o(cell_match[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.push) begin
      count_d = count_q + CW'(1);
    end else if (ctl.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    rd_d     = '0;
    fpos_d   = '0;
    found_d  = 1'b0;
    status_d = ilt_pkg::ST_OK;
    for (int k = 0; k < DEPTH; k++) begin
      if (is_read && cell_hit[k]) begin
        rd_d = rd_d | cell_data[k];
      end
      if (is_find && cell_match[k]) begin
        found_d = 1'b1;
        fpos_d  = IW'(k);
      end
    end
    if (is_push && full) begin
      status_d = ilt_pkg::ST_FULL;
    end else if ((is_read || is_write || is_remove) && !in_range) begin
      status_d = ilt_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rd_q     <= rd_d;
      fpos_q   <= fpos_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign done_o           = done_q;
  assign read_value_o     = ilt_pkg::VAL_W'(64'(rd_q));
  assign found_position_o = ilt_pkg::POS_W'(fpos_q);
  assign found_o          = found_q;
  assign status_o         = status_q;
  assign count_o          = ilt_pkg::CNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("count above depth");

  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && is_push && full |=> done_o && status_o == ilt_pkg::ST_FULL && $stable(count_q))
    else $error("push to full list not refused");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && is_remove && in_range |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not drop count");

  a_found_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !is_find |=> !found_o)
    else $error("found raised for a non-find item");

  a_range_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (is_read || is_write || is_remove) && !in_range |=>
      status_o == ilt_pkg::ST_RANGE && $stable(count_q))
    else $error("out of range item changed count");

endmodule
